FILE: src/mh64_pkg.sv
// Shared types and constants for the MurmurHash64A hash core.
// No dependencies; imported by every module of the core.
`default_nettype none

package mh64_pkg;

    localparam logic [63:0] MURMUR_M = 64'hc6a4a7935bd1e995;
    localparam int          MURMUR_R = 47;

    // Configuration register map: register index is paddr[2]
    localparam int   ADDR_W       = 3;
    localparam logic REG_IDX_SEED = 1'b0;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_TAIL,
        KIND_FULL
    } t_kind;

    // Classified input item, as queued between front and back
    typedef struct packed {
        logic [63:0] word;
        t_kind       kind;
        logic        first;
        logic [31:0] total_length;
        logic        last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MIX1,
        ST_MIX2,
        ST_HMUL,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;

endpackage

`default_nettype wire

FILE: src/murmur64a_hash_core.sv
// MurmurHash64A streaming hash core: top level with configuration port.
// Depends on mh64_pkg, mh64_front, mh64_queue, mh64_back.
//
// Usage:
//   Input queue: present a word with push while full is low. The first item of
//   a message carries first=1 and total_length; the item with last=1 closes it.
//   valid_bytes is 8 for full words, 1..7 for the tail, 0 for an empty message.
//   Result queue: while empty is low, o_hash holds the finalized hash of the
//   oldest completed message; pop takes it.
//   Config: APB write to address 0 sets the 32-bit seed; used by the next
//   item with first=1. Write only while the core is idle.
// Timing:
//   Each 64-bit multiply by the hash constant runs on one shared 32x32
//   multiplier, in steps: issue, three partial products, capture.
//   An item costs a dispatch step plus one multiply if first, three for a
//   full word, one for a tail word, and one plus an output step if last.
//   The sequencer is the limit.
//   A queue of QUEUE_DEPTH items decouples input acceptance from processing.
// Reset: queues empty, seed and running hash cleared.
// Stall: if the result is not popped, the sequencer waits at a finished
//   message while the input queue keeps filling until full.
`default_nettype none

module murmur64a_hash_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [63:0]                 i_word,
    input  wire logic [3:0]                  i_valid_bytes,
    input  wire logic                        i_first,
    input  wire logic [31:0]                 i_total_length,
    input  wire logic                        i_last,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [63:0]                      o_hash,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mh64_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import mh64_pkg::*;

    logic [31:0] r_seed;
    t_item       front_item, q_item;
    logic        q_empty, q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_SEED) ? r_seed : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_SEED)) begin
            r_seed <= pwdata;
        end
    end

    mh64_front u_front (
        .i_word         (i_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_first        (i_first),
        .i_total_length (i_total_length),
        .i_last         (i_last),
        .o_item         (front_item)
    );

    mh64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    mh64_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed    (r_seed),
        .i_q_empty (q_empty),
        .i_item    (q_item),
        .o_q_pop   (q_pop),
        .o_hash    (o_hash),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

`default_nettype wire

FILE: src/mh64_front.sv
// Front end: classifies an incoming word as full, tail or empty and masks tail bytes.
// Depends on mh64_pkg.
`default_nettype none

module mh64_front (
    input  wire logic [63:0]   i_word,
    input  wire logic [3:0]    i_valid_bytes,
    input  wire logic          i_first,
    input  wire logic [31:0]   i_total_length,
    input  wire logic          i_last,
    output mh64_pkg::t_item    o_item
);
    import mh64_pkg::*;

    logic [63:0] masked;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            masked[i*8 +: 8] = (3'(i) < i_valid_bytes[2:0]) ? i_word[i*8 +: 8] : 8'h00;
        end
    end

    always_comb begin
        o_item.first        = i_first;
        o_item.total_length = i_total_length;
        o_item.last         = i_last;
        if (i_valid_bytes[3]) begin
            // 8 and above: full word
            o_item.kind = KIND_FULL;
            o_item.word = i_word;
        end else if (i_valid_bytes == 4'd0) begin
            o_item.kind = KIND_NONE;
            o_item.word = '0;
        end else begin
            o_item.kind = KIND_TAIL;
            o_item.word = masked;
        end
    end

endmodule

`default_nettype wire

FILE: src/mh64_queue.sv
// Small FIFO of classified items between the front end and the sequencer.
// Depends on mh64_pkg.
`default_nettype none

module mh64_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  mh64_pkg::t_item    i_item,
    output logic               o_full,
    input  wire logic          i_pop,
    output mh64_pkg::t_item    o_item,
    output logic               o_empty
);
    import mh64_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/mh64_mul.sv
// Multiplies a 64-bit operand by the hash constant modulo 2^64, using one
// 32x32 multiplier in three partial-product steps. Depends on mh64_pkg.
`default_nettype none

module mh64_mul (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  mh64_pkg::t_mul_req i_req,
    output mh64_pkg::t_mul_rsp o_rsp
);
    import mh64_pkg::*;

    logic        r_busy, r_done;
    logic [1:0]  r_step;
    logic [63:0] r_a, r_acc;
    logic [31:0] mx, my;
    logic [63:0] prod;

    // step 0: lo*lo, step 1: hi*Mlo, step 2: lo*Mhi (cross terms only need low halves)
    assign mx   = (r_step == 2'd1) ? r_a[63:32] : r_a[31:0];
    assign my   = (r_step == 2'd2) ? MURMUR_M[63:32] : MURMUR_M[31:0];
    assign prod = 64'(mx) * 64'(my);

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
        end else if (r_busy) begin
            if (r_step == 2'd0) begin
                r_acc <= prod;
            end else begin
                r_acc[63:32] <= r_acc[63:32] + prod[31:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/mh64_back.sv
// Back end: sequences seeding, word mixing and finalization on the shared
// multiplier and holds the result slot. Depends on mh64_pkg and mh64_mul.
`default_nettype none

module mh64_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_seed,
    input  wire logic          i_q_empty,
    input  mh64_pkg::t_item    i_item,
    output logic               o_q_pop,
    output logic [63:0]        o_hash,
    output logic               o_empty,
    input  wire logic          i_pop
);
    import mh64_pkg::*;

    t_state      r_state, n_state;
    t_item       r_cur, n_cur;
    logic [63:0] r_h, n_h;
    logic [63:0] r_k, n_k;
    logic        r_wait, n_wait;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_hash, n_hash;
    logic [63:0] h_base;
    t_mul_req    mul_req;
    t_mul_rsp    mul_rsp;

    function automatic t_state route(t_kind kind, logic last);
        case (kind)
            KIND_FULL: route = ST_MIX1;
            KIND_TAIL: route = ST_HMUL;
            default:   route = last ? ST_FIN : ST_IDLE;
        endcase
    endfunction

    mh64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign o_hash  = r_hash;
    assign o_empty = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_h         <= '0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
            r_h         <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_k    <= n_k;
        r_hash <= n_hash;
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_h         = r_h;
        n_k         = r_k;
        n_wait      = r_wait;
        n_out_valid = r_out_valid && !i_pop;
        n_hash      = r_hash;
        o_q_pop     = 1'b0;
        mul_req     = '0;
        h_base      = r_h;

        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_item;
                    if (i_item.first) begin
                        n_state = ST_INIT;
                    end else begin
                        n_state = route(i_item.kind, i_item.last);
                        if (i_item.kind == KIND_TAIL) begin
                            n_h = r_h ^ i_item.word;
                        end
                    end
                end
            end
            ST_INIT: begin
                mul_req.a = {32'd0, r_cur.total_length};
                if (mul_rsp.done) begin
                    h_base  = {32'd0, i_seed} ^ mul_rsp.p;
                    n_h     = (r_cur.kind == KIND_TAIL) ? (h_base ^ r_cur.word) : h_base;
                    n_state = route(r_cur.kind, r_cur.last);
                end
            end
            ST_MIX1: begin
                mul_req.a = r_cur.word;
                if (mul_rsp.done) begin
                    n_k     = mul_rsp.p ^ (mul_rsp.p >> MURMUR_R);
                    n_state = ST_MIX2;
                end
            end
            ST_MIX2: begin
                mul_req.a = r_k;
                if (mul_rsp.done) begin
                    n_h     = r_h ^ mul_rsp.p;
                    n_state = ST_HMUL;
                end
            end
            ST_HMUL: begin
                mul_req.a = r_h;
                if (mul_rsp.done) begin
                    n_h     = mul_rsp.p;
                    n_state = r_cur.last ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                mul_req.a = r_h ^ (r_h >> MURMUR_R);
                if (mul_rsp.done) begin
                    // final value parked in r_k until the result slot frees up
                    n_k     = mul_rsp.p ^ (mul_rsp.p >> MURMUR_R);
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_hash      = r_k;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (r_state inside {ST_INIT, ST_MIX1, ST_MIX2, ST_HMUL, ST_FIN}) begin
            if (!r_wait) begin
                mul_req.start = 1'b1;
                n_wait        = 1'b1;
            end else if (mul_rsp.done) begin
                n_wait = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/mh64_checker.sv
// Port-level checks for the MurmurHash64A core, bound to the top level.
// Depends on mh64_pkg and murmur64a_hash_core.
`default_nettype none

module mh64_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire logic [63:0]                 o_hash,
    input wire logic                        psel,
    input wire logic                        penable,
    input wire logic                        pwrite,
    input wire logic [mh64_pkg::ADDR_W-1:0] paddr,
    input wire logic [31:0]                 pwdata,
    input wire logic [31:0]                 prdata,
    input wire logic                        pready
);
    import mh64_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hash_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_hash)))
        else $error("waiting result changed or vanished");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_seed_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_SEED))
        |=> ((paddr[2] != REG_IDX_SEED) || (prdata == $past(pwdata))))
        else $error("seed readback mismatch");

endmodule

bind murmur64a_hash_core mh64_checker u_mh64_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_hash  (o_hash),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
);

`default_nettype wire

FILE: dv/murmur64a_hash_core_test.sv
// Self-checking testbench for murmur64a_hash_core: directed and random messages
// against an in-bench MurmurHash64A predictor, under several seed settings.
// Depends on mh64_pkg and the murmur64a_hash_core RTL.
`default_nettype none

module murmur64a_hash_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mh64_pkg::*;

    localparam logic [63:0] HASH_MULT  = 64'hc6a4a7935bd1e995;
    localparam int          HASH_SHIFT = 47;
    localparam logic [3:0]  VB_FULL    = 4'd8;
    localparam logic [3:0]  VB_NONE    = 4'd0;
    localparam logic [ADDR_W-1:0] SEED_ADDR = {REG_IDX_SEED, 2'b00};
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 170;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  valid_bytes;
        logic        first;
        logic [31:0] total_length;
        logic        last;
    } t_feed_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [63:0] i_word = '0;
    logic [3:0]  i_valid_bytes = '0;
    logic        i_first = 1'b0;
    logic [31:0] i_total_length = '0;
    logic        i_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] o_hash;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_feed_item  feed_q[$];
    logic [63:0] hash_expect_q[$];
    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned hashes_checked = 0;
    int unsigned message_count = 0;
    int unsigned seed_settings = 1;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    murmur64a_hash_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_word         (i_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_first        (i_first),
        .i_total_length (i_total_length),
        .i_last         (i_last),
        .empty          (empty),
        .pop            (pop),
        .o_hash         (o_hash),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] scramble_word(input logic [63:0] k);
        k = k * HASH_MULT;
        k = k ^ (k >> HASH_SHIFT);
        k = k * HASH_MULT;
        return k;
    endfunction

    function automatic logic [63:0] finish_hash(input logic [63:0] h);
        h = h ^ (h >> HASH_SHIFT);
        h = h * HASH_MULT;
        h = h ^ (h >> HASH_SHIFT);
        return h;
    endfunction

    logic [63:0] acc_hash;
    logic [31:0] seed_shadow;

    always @(posedge i_clk) begin : scoreboard
        logic [63:0] h;
        logic [63:0] tail_mask;
        int unsigned nb;
        if (!i_rst_n) begin
            acc_hash = '0;
            seed_shadow = '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
                seed_shadow = pwdata;
            if (push && !full) begin
                accepted_count++;
                nb = (i_valid_bytes > VB_FULL) ? 8 : i_valid_bytes;
                h = acc_hash;
                if (i_first)
                    h = {32'b0, seed_shadow} ^ ({32'b0, i_total_length} * HASH_MULT);
                if (nb == 8) begin
                    h = (h ^ scramble_word(i_word)) * HASH_MULT;
                end else if (nb != 0) begin
                    tail_mask = (64'd1 << (nb * 8)) - 64'd1;
                    h = (h ^ (i_word & tail_mask)) * HASH_MULT;
                end
                acc_hash = h;
                if (i_last)
                    hash_expect_q.push_back(finish_hash(h));
            end
            if (pop && !empty) begin
                if (hash_expect_q.size() == 0) begin
                    $error("unexpected hash transaction: actual %h", o_hash);
                    fail_count++;
                end else begin
                    h = hash_expect_q.pop_front();
                    hashes_checked++;
                    if (o_hash !== h) begin
                        $error("hash mismatch: expected %h, actual %h", h, o_hash);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ---------------- input driver: bursts with random gaps ----------------
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin : feeder
        t_feed_item it;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end else if (feed_q.size() == 0) begin
                push <= 1'b0;
            end else begin
                it = feed_q.pop_front();
                push           <= 1'b1;
                i_word         <= it.word;
                i_valid_bytes  <= it.valid_bytes;
                i_first        <= it.first;
                i_total_length <= it.total_length;
                i_last         <= it.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ---------------- result side: rotating stall pattern ----------------
    logic [31:0] pop_pattern = '1;
    int unsigned pattern_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= pop_pattern[0];
            if (pattern_left == 0) begin
                pattern_left <= $urandom_range(16, 96);
                // a quarter of the stretches never stall
                pop_pattern  <= ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h1);
            end else begin
                pattern_left <= pattern_left - 1;
                pop_pattern  <= {pop_pattern[0], pop_pattern[31:1]};
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_item(input logic [63:0] w, input logic [3:0] vb, input logic f,
                            input logic [31:0] len, input logic l);
        t_feed_item it;
        it.word = w;
        it.valid_bytes = vb;
        it.first = f;
        it.total_length = len;
        it.last = l;
        feed_q.push_back(it);
        queued_count++;
    endtask

    // One message of nbytes bytes; high bytes of the tail word and the length
    // field of later transactions are random since the block ignores them.
    task automatic add_message(input int unsigned nbytes, input logic [31:0] len,
                               input logic with_first);
        int unsigned nfull;
        int unsigned tail;
        logic [3:0]  vb;
        nfull = nbytes / 8;
        tail  = nbytes % 8;
        message_count++;
        if (nbytes == 0) begin
            add_item(rand64(), VB_NONE, with_first, len, 1'b1);
        end else begin
            for (int i = 0; i < nfull; i++) begin
                vb = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : VB_FULL;
                add_item(rand64(), vb, with_first && i == 0,
                         (i == 0) ? len : $urandom, tail == 0 && i == nfull - 1);
            end
            if (tail != 0)
                add_item(rand64(), 4'(tail), with_first && nfull == 0,
                         (nfull == 0) ? len : $urandom, 1'b1);
        end
    endtask

    task automatic add_random_phase();
        int unsigned start;
        int unsigned nbytes;
        int unsigned pick;
        start = queued_count;
        while (queued_count - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                add_item(rand64(), 4'($urandom_range(0, 15)), 1'($urandom),
                         $urandom, 1'($urandom));
            end else begin
                case ($urandom_range(0, 19))
                    0:       nbytes = $urandom_range(121, 300);
                    1, 2, 3: nbytes = $urandom_range(41, 120);
                    default: nbytes = $urandom_range(0, 40);
                endcase
                if (pick < 16)
                    add_message(nbytes, $urandom, 1'b1);          // wrong length
                else if (pick < 19)
                    add_message(nbytes, nbytes, 1'b0);            // no first marker
                else
                    add_message(nbytes, nbytes, 1'b1);
            end
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || hash_expect_q.size() != 0)
            @(posedge i_clk);
        // an item without a result may still be in the sequencer
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_seed(input logic [31:0] value);
        logic [31:0] rd;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SEED_ADDR;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        paddr <= SEED_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== value) begin
            $error("seed readback mismatch: expected %h, actual %h", value, rd);
            fail_count++;
        end
        seed_settings++;
    endtask

    initial begin : stimulus
        logic [31:0] seed_list[6];
        seed_list = '{32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, $urandom, $urandom, 32'h0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, seed at its reset value
        add_item(rand64(), VB_FULL, 1'b0, $urandom, 1'b1);           // no first after reset
        add_item(rand64(), VB_NONE, 1'b1, 32'd0, 1'b1);              // empty message
        add_item('1, VB_FULL, 1'b1, 32'd8, 1'b1);
        add_item('0, VB_FULL, 1'b1, 32'd8, 1'b1);
        add_item('1, VB_FULL, 1'b1, 32'd15, 1'b0);
        add_item('1, 4'd7, 1'b0, 32'hffff_ffff, 1'b1);
        for (int n = 1; n < 8; n++)
            add_item('1, 4'(n), 1'b1, 32'(n), 1'b1);
        add_item(rand64(), 4'd15, 1'b1, 32'd8, 1'b1);                // oversize count
        add_item(rand64(), 4'd9, 1'b1, 32'd8, 1'b1);
        add_item(rand64(), 4'd3, 1'b1, 32'd11, 1'b0);                // tail before last
        add_item(rand64(), VB_FULL, 1'b0, 32'd0, 1'b1);
        add_item(rand64(), VB_FULL, 1'b1, 32'hffff_ffff, 1'b1);      // inconsistent length
        add_item(rand64(), VB_FULL, 1'b0, 32'd0, 1'b0);              // continues after last
        add_item(rand64(), 4'd2, 1'b0, 32'd0, 1'b1);
        message_count += 17;
        add_random_phase();
        wait_idle();

        foreach (seed_list[i]) begin
            program_seed(seed_list[i]);
            add_random_phase();
            wait_idle();
        end

        $display("Ran %0d input transactions (%0d messages) under %0d seed settings;",
                 accepted_count, message_count, seed_settings);
        $display("checked %0d hash results with randomized input gaps and output stalls.",
                 hashes_checked);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
src/mh64_pkg.sv
src/mh64_front.sv
src/mh64_queue.sv
src/mh64_mul.sv
src/mh64_back.sv
src/murmur64a_hash_core.sv
src/mh64_checker.sv
dv/murmur64a_hash_core_test.sv
